// ----- design/rlb_pkg.sv -----
package rlb_pkg;

    // fixed field widths of the stream payloads
    localparam int FIELD_W      = 48;
    localparam int PICK_W       = 16;
    localparam int S_TDATA_W    = 160;
    localparam int M_TDATA_W    = 96;

    // remainder arithmetic covers divisors up to 64
    localparam int REM_W        = 7;
    localparam int VICTIM_MAX_W = 6;

    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_INSERT = 1'b1
    } rlb_mode_t;

    // insert command toward the entry array
    typedef struct packed {
        logic                    insert;
        logic [VICTIM_MAX_W-1:0] victim;
    } rlb_cmd_t;

endpackage

// ----- design/range_lookaside_buffer_core.sv -----
// range lookaside buffer: ordered, fully associative list of up to ENTRIES
// address ranges [base, bound)
// input channel s_*: s_tuser is the mode (0 lookup, 1 insert); s_tdata carries
//   address, range base, range bound and the random victim pick
// result channel m_*: one transfer per input transfer, in order; m_tuser is
//   the hit flag, m_tdata the matched base and bound (zero on miss or insert)
// lookups return the first matching entry and mark its position as most
//   recently used; an insert on a full list evicts the entry at pick mod
//   ENTRIES (stepped past the recent position), closes the gap and appends
// path: input register, then one pass of parallel range compares into the
//   result register
// throughput: 1 item per cycle while m_tready holds, via one compare/update
//   pass; each item sees the entry state written by the item before it
// receiver stall: the result register holds, the input register still takes
//   one more item, then s_tready drops until m_tready returns
// reset: entry count and recent position clear, both stages empty; entry
//   contents are not cleared and are only read below the entry count
module range_lookaside_buffer_core #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 48
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: address[47:0], range_base[95:48], range_bound[143:96],
    //          random_pick[159:144]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rlb_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [0:0]                       s_tuser,   // mode
    // m_tdata: hit_base[47:0], hit_bound[95:48]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rlb_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [0:0]                       m_tuser    // hit
);
    import rlb_pkg::*;

    // stored width: the smaller of ADDR_BITS and the 48-bit field width
    localparam int SW = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
    localparam int VW = $clog2(ENTRIES);
    localparam logic [VW-1:0]    LAST_POS = VW'(ENTRIES - 1);
    localparam logic [REM_W-1:0] DIVISOR  = REM_W'(ENTRIES);
    // reciprocal of ENTRIES scaled by 2^32, quotient is exact or one short
    localparam int               PROD_W   = PICK_W + 32;
    localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / 64'(ENTRIES));

    // input register
    logic             in_valid_reg;
    rlb_mode_t        in_mode_reg;
    logic [SW-1:0]    in_addr_reg;
    logic [SW-1:0]    in_base_reg;
    logic [SW-1:0]    in_bound_reg;
    logic [VW-1:0]    in_pick_rem_reg;   // pick already reduced mod ENTRIES

    // result register
    logic                 m_tvalid_reg;
    logic                 out_hit_reg;
    logic [FIELD_W-1:0]   out_base_reg;
    logic [FIELD_W-1:0]   out_bound_reg;

    logic [VW-1:0] recent_reg;
    logic [VW-1:0] recent_next;

    logic          s_xfer;
    logic          fire;
    logic          is_insert;
    logic [PICK_W-1:0] s_pick;
    logic [PROD_W-1:0] pick_prod;
    logic [PICK_W-1:0] pick_quot;
    logic [PICK_W-1:0] pick_diff;
    logic [REM_W-1:0]  pick_rem;
    logic [VW-1:0] victim_raw;
    logic [VW-1:0] victim;
    rlb_cmd_t      cmd;

    logic [ENTRIES-1:0] match;
    logic [SW-1:0]      base_q  [ENTRIES];
    logic [SW-1:0]      bound_q [ENTRIES];
    logic               hit;
    logic [VW-1:0]      hit_idx;
    logic [SW-1:0]      hit_base;
    logic [SW-1:0]      hit_bound;

    // pass proceeds when the result register is free or being drained
    assign fire     = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_xfer   = s_tvalid && s_tready;
    assign is_insert = (in_mode_reg == MODE_INSERT);

    // pick mod ENTRIES ahead of the input register: reciprocal multiply,
    // then at most one compare and subtract
    always_comb begin
        s_pick    = s_tdata[3*FIELD_W+PICK_W-1:3*FIELD_W];
        pick_prod = PROD_W'(s_pick) * PROD_W'(RECIP);
        pick_quot = pick_prod[PROD_W-1:32];
        pick_diff = s_pick - pick_quot * PICK_W'(ENTRIES);
        pick_rem  = pick_diff[REM_W-1:0];
        if (pick_rem >= DIVISOR) begin
            pick_rem = pick_rem - DIVISOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_mode_reg     <= rlb_mode_t'(s_tuser[0]);
            in_addr_reg     <= s_tdata[SW-1:0];
            in_base_reg     <= s_tdata[FIELD_W+SW-1:FIELD_W];
            in_bound_reg    <= s_tdata[2*FIELD_W+SW-1:2*FIELD_W];
            in_pick_rem_reg <= pick_rem[VW-1:0];
        end
    end

    // victim: pick mod ENTRIES, stepped past the recent position
    always_comb begin
        victim_raw = in_pick_rem_reg;
        victim     = victim_raw;
        if (victim_raw == recent_reg) begin
            victim = (victim_raw == LAST_POS) ? '0 : victim_raw + VW'(1);
        end
        cmd.insert = fire && is_insert;
        cmd.victim = VICTIM_MAX_W'(victim);
    end

    rlb_entry_array #(
        .ENTRIES (ENTRIES),
        .SW      (SW)
    ) u_entries (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .ins_base    (in_base_reg),
        .ins_bound   (in_bound_reg),
        .lookup_addr (in_addr_reg),
        .match       (match),
        .base_q      (base_q),
        .bound_q     (bound_q)
    );

    rlb_hit_select #(
        .ENTRIES (ENTRIES),
        .SW      (SW)
    ) u_hit_sel (
        .match     (match),
        .base_q    (base_q),
        .bound_q   (bound_q),
        .hit       (hit),
        .hit_idx   (hit_idx),
        .hit_base  (hit_base),
        .hit_bound (hit_bound)
    );

    // only a lookup hit moves the recent position
    always_comb begin
        recent_next = recent_reg;
        if (fire && !is_insert && hit) begin
            recent_next = hit_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            recent_reg <= recent_next;
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (!is_insert && hit) begin
                out_hit_reg   <= 1'b1;
                out_base_reg  <= FIELD_W'(hit_base);
                out_bound_reg <= FIELD_W'(hit_bound);
            end else begin
                out_hit_reg   <= 1'b0;
                out_base_reg  <= '0;
                out_bound_reg <= '0;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = out_hit_reg;
    assign m_tdata    = {out_bound_reg, out_base_reg};

    // a miss or insert result carries zero data
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss result with nonzero data");

    // an insert always produces a no-hit result
    a_insert_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && is_insert |=> m_tvalid && !m_tuser[0])
        else $error("insert produced a hit");

    // input side only blocks while the result is stalled
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // recent position stays within the list
    a_recent_range: assert property (@(posedge aclk) disable iff (!aresetn)
        recent_reg <= LAST_POS)
        else $error("recent position out of range");

endmodule

// ----- design/rlb_entry_array.sv -----
module rlb_entry_array #(
    parameter int ENTRIES = 16,
    parameter int SW      = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rlb_pkg::rlb_cmd_t cmd,
    input  logic [SW-1:0]     ins_base,
    input  logic [SW-1:0]     ins_bound,
    input  logic [SW-1:0]     lookup_addr,
    output logic [ENTRIES-1:0] match,
    output logic [SW-1:0]     base_q  [ENTRIES],
    output logic [SW-1:0]     bound_q [ENTRIES]
);
    import rlb_pkg::*;

    localparam int VW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [SW-1:0] base_reg  [ENTRIES];
    logic [SW-1:0] bound_reg [ENTRIES];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    logic [VW-1:0] wr_idx;
    logic [VW-1:0] victim;

    always_comb begin
        full   = (count_reg == CW'(ENTRIES));
        wr_idx = count_reg[VW-1:0];
        victim = cmd.victim[VW-1:0];
    end

    // full list: entries at and above the victim slide down, new range goes last
    for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
        if (i == ENTRIES - 1) begin : g_last
            always_ff @(posedge aclk) begin
                if (cmd.insert && (full || wr_idx == VW'(i))) begin
                    base_reg[i]  <= ins_base;
                    bound_reg[i] <= ins_bound;
                end
            end
        end else begin : g_mid
            always_ff @(posedge aclk) begin
                if (cmd.insert) begin
                    if (full) begin
                        if (VW'(i) >= victim) begin
                            base_reg[i]  <= base_reg[i+1];
                            bound_reg[i] <= bound_reg[i+1];
                        end
                    end else if (wr_idx == VW'(i)) begin
                        base_reg[i]  <= ins_base;
                        bound_reg[i] <= ins_bound;
                    end
                end
            end
        end

        assign match[i] = (CW'(i) < count_reg)
                       && (lookup_addr >= base_reg[i])
                       && (lookup_addr <  bound_reg[i]);
        assign base_q[i]  = base_reg[i];
        assign bound_q[i] = bound_reg[i];
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert && !full) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/rlb_hit_select.sv -----
module rlb_hit_select #(
    parameter int ENTRIES = 16,
    parameter int SW      = 48
) (
    input  logic [ENTRIES-1:0]         match,
    input  logic [SW-1:0]              base_q  [ENTRIES],
    input  logic [SW-1:0]              bound_q [ENTRIES],
    output logic                       hit,
    output logic [$clog2(ENTRIES)-1:0] hit_idx,
    output logic [SW-1:0]              hit_base,
    output logic [SW-1:0]              hit_bound
);
    import rlb_pkg::*;

    localparam int VW = $clog2(ENTRIES);

    logic [ENTRIES-1:0] first;

    // lowest set bit wins
    assign first = match & (~match + ENTRIES'(1));
    assign hit   = |match;

    always_comb begin
        hit_idx   = '0;
        hit_base  = '0;
        hit_bound = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (first[i]) begin
                hit_idx = hit_idx | VW'(i);
            end
            hit_base  = hit_base  | (base_q[i]  & {SW{first[i]}});
            hit_bound = hit_bound | (bound_q[i] & {SW{first[i]}});
        end
    end

endmodule
